@@ design/mfrsc_pkg.sv @@
package mfrsc_pkg;

	localparam int MAX_FRAME_WORDS_DEF = 64;

	localparam int SEQ_W   = 16;
	localparam int CNT_W   = 32;
	localparam int STAT_W  = 3;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 120;

	localparam logic [7:0] END_BYTE = 8'hFF;

	localparam logic [STAT_W-1:0] ST_GOOD      = 3'd0;
	localparam logic [STAT_W-1:0] ST_DROP      = 3'd1;
	localparam logic [STAT_W-1:0] ST_OVF       = 3'd2;
	localparam logic [STAT_W-1:0] ST_DATA_FOOT = 3'd3;
	localparam logic [STAT_W-1:0] ST_DROP_FOOT = 3'd4;
	localparam logic [STAT_W-1:0] ST_OVF_FOOT  = 3'd5;

endpackage

@@ design/marked_frame_receiver_seq_check.sv @@
// A closing word's result is registered and shown in the cycle after its transfer.
// Throughput: one word per cycle; single registered pass over frame state,
// sequence check and counters, gated only by a stalled result register.
// A word that does not close a frame produces no result.
// Reset (arst_n low, asynchronous): idle, no frame open, captured bytes,
// last sequence and all totals cleared to zero, no result pending.
module marked_frame_receiver_seq_check
	import mfrsc_pkg::*;
#(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // frame_valid, data_byte, zero pad
	input  logic             s_tuser,   // marker_bit
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // frame_status, sequence_number, gap_seen,
	                                    // error_total, miss_total, good_total, zero pad
);

	localparam int IDX_W = $clog2(MAX_FRAME_WORDS + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_WORDS);

	logic             in_frame_q;
	logic [IDX_W-1:0] idx_q;
	logic             foot_q;
	logic [7:0]       lo_q;
	logic [7:0]       hi_q;
	logic [SEQ_W-1:0] last_q;
	logic [CNT_W-1:0] err_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] good_q;
	logic             out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic             gap_q;

	logic             valid_in;
	logic             marker_in;
	logic [7:0]       byte_in;
	logic             accept;

	logic             in_frame_n;
	logic [IDX_W-1:0] idx_n;
	logic             foot_n;
	logic [7:0]       lo_n;
	logic [7:0]       hi_n;
	logic [IDX_W-1:0] cur_idx;
	logic             cur_foot;
	logic             closing;
	logic [STAT_W-1:0] status_n;
	logic             ovf;
	logic [SEQ_W-1:0] seq_n;
	logic             gap_n;
	logic [SEQ_W:0]   miss_add;

	assign valid_in  = s_tdata[0];
	assign byte_in   = s_tdata[8:1];
	assign marker_in = s_tuser;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_frame_n = in_frame_q;
		idx_n      = idx_q;
		foot_n     = foot_q;
		lo_n       = lo_q;
		hi_n       = hi_q;
		cur_idx    = idx_q;
		cur_foot   = foot_q;
		closing    = 1'b0;
		status_n   = ST_GOOD;
		ovf        = in_frame_q && (idx_q >= IDX_MAX);
		if (ovf) begin
			closing    = 1'b1;
			status_n   = foot_q ? ST_OVF_FOOT : ST_OVF;
			in_frame_n = 1'b0;
		end
		if ((in_frame_q && !ovf) || valid_in) begin
			if (ovf || !in_frame_q) begin
				in_frame_n = 1'b1;
				cur_idx    = '0;
				cur_foot   = 1'b0;
				idx_n      = '0;
				foot_n     = 1'b0;
			end
			if (cur_idx == IDX_W'(1)) begin
				lo_n = byte_in;
			end else if (cur_idx == IDX_W'(2)) begin
				hi_n = byte_in;
			end
			if (!valid_in) begin
				closing    = 1'b1;
				status_n   = cur_foot ? ST_DROP_FOOT : ST_DROP;
				in_frame_n = 1'b0;
			end else if (cur_foot) begin
				if (!marker_in) begin
					closing    = 1'b1;
					status_n   = ST_DATA_FOOT;
					in_frame_n = 1'b0;
				end else if (byte_in == END_BYTE) begin
					closing    = 1'b1;
					status_n   = ST_GOOD;
					in_frame_n = 1'b0;
				end else begin
					idx_n = cur_idx + IDX_W'(1);
				end
			end else begin
				foot_n = marker_in;
				idx_n  = cur_idx + IDX_W'(1);
			end
		end
	end

	assign seq_n = {hi_n, lo_n};
	assign gap_n = (status_n == ST_GOOD) && (seq_n != last_q + SEQ_W'(1));

	always_comb begin
		if (seq_n > last_q) begin
			miss_add = {1'b0, seq_n} - {1'b0, last_q} + (SEQ_W+1)'(1);
		end else begin
			miss_add = {1'b0, seq_n} + {1'b1, {SEQ_W{1'b0}}} - {1'b0, last_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			idx_q       <= '0;
			foot_q      <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			last_q      <= '0;
			err_q       <= '0;
			miss_q      <= '0;
			good_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_GOOD;
			gap_q       <= 1'b0;
		end else begin
			if (accept && closing) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				in_frame_q <= in_frame_n;
				idx_q      <= idx_n;
				foot_q     <= foot_n;
				lo_q       <= lo_n;
				hi_q       <= hi_n;
				if (closing) begin
					status_q    <= status_n;
					gap_q       <= gap_n;
					last_q      <= seq_n;
					if (status_n != ST_GOOD) begin
						err_q <= err_q + CNT_W'(1);
					end else if (gap_n) begin
						miss_q <= miss_q + CNT_W'(miss_add);
					end else begin
						good_q <= good_q + CNT_W'(1);
					end
				end
			end
		end
	end

	// totals and sequence only change when a result is loaded
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, good_q, miss_q, err_q, gap_q, last_q, status_q};

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	a_gap_good_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && gap_q) |-> (status_q == ST_GOOD))
		else $error("gap flagged on error frame");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && closing && status_n != ST_GOOD) |=> (err_q == $past(err_q) + CNT_W'(1)))
		else $error("error total not advanced");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (idx_q <= IDX_MAX))
		else $error("word index past frame limit");

endmodule

@@ test/tb_marked_frame_receiver_seq_check.sv @@
module tb_marked_frame_receiver_seq_check;
	import mfrsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LIMIT   = MAX_FRAME_WORDS_DEF;
	localparam int RANDOM_WORDS  = 1100;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SHOWN_ERRORS  = 10;

	typedef enum int {END_GOOD, END_DROP, END_DATA, END_OPEN} frame_end_t;

	typedef struct packed {
		logic [CNT_W-1:0]  good;
		logic [CNT_W-1:0]  miss;
		logic [CNT_W-1:0]  err;
		logic              gap;
		logic [SEQ_W-1:0]  seq;
		logic [STAT_W-1:0] status;
	} frame_report_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             s_tuser  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	frame_report_t expected_reports[$];

	bit          steady;
	int          mismatches;
	int          words_taken;
	int          cycle_count;
	logic [15:0] planned_seq;

	logic              frame_open;
	logic [6:0]        word_pos;
	logic              in_footer;
	logic [7:0]        low_b;
	logic [7:0]        high_b;
	logic [SEQ_W-1:0]  prev_seq;
	logic [CNT_W-1:0]  err_cnt;
	logic [CNT_W-1:0]  miss_cnt;
	logic [CNT_W-1:0]  good_cnt;

	marked_frame_receiver_seq_check #(
		.MAX_FRAME_WORDS(FRAME_LIMIT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin
		frame_report_t got;
		frame_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = frame_report_t'(m_tdata[$bits(frame_report_t)-1:0]);
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected frame report: status %0d seq %h", got.status, got.seq);
			end else begin
				want = expected_reports.pop_front();
				if (got.status !== want.status || got.seq !== want.seq || got.gap !== want.gap ||
				    got.err !== want.err || got.miss !== want.miss || got.good !== want.good) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS) begin
						$display("report mismatch: expected st %0d seq %h gap %0d err %0d miss %0d good %0d",
						         want.status, want.seq, want.gap, want.err, want.miss, want.good);
						$display("                 got      st %0d seq %h gap %0d err %0d miss %0d good %0d",
						         got.status, got.seq, got.gap, got.err, got.miss, got.good);
					end
				end
			end
		end
	end

	task automatic close_frame(input logic [STAT_W-1:0] st);
		frame_report_t rpt;
		logic [SEQ_W-1:0] num;
		logic gap;
		num = {high_b, low_b};
		gap = 1'b0;
		if (st != ST_GOOD) begin
			err_cnt = err_cnt + 1;
		end else if ({1'b0, num} != {1'b0, prev_seq} + 17'd1 &&
		             !(num == '0 && prev_seq == '1)) begin
			gap = 1'b1;
			if (num > prev_seq)
				miss_cnt = miss_cnt + 32'(num) - 32'(prev_seq) + 32'd1;
			else
				miss_cnt = miss_cnt + 32'(num) + 32'd65536 - 32'(prev_seq);
		end else begin
			good_cnt = good_cnt + 1;
		end
		prev_seq   = num;
		frame_open = 1'b0;
		rpt.status = st;
		rpt.seq    = num;
		rpt.gap    = gap;
		rpt.err    = err_cnt;
		rpt.miss   = miss_cnt;
		rpt.good   = good_cnt;
		expected_reports.push_back(rpt);
	endtask

	task automatic predict_word(input logic fv, input logic mk, input logic [7:0] b);
		if (frame_open || fv)
			words_taken++;
		if (frame_open && word_pos >= FRAME_LIMIT)
			close_frame(in_footer ? ST_OVF_FOOT : ST_OVF);
		if (!frame_open) begin
			if (!fv)
				return;
			frame_open = 1'b1;
			word_pos   = '0;
			in_footer  = 1'b0;
		end
		if (word_pos == 7'd1)
			low_b = b;
		else if (word_pos == 7'd2)
			high_b = b;
		if (!fv) begin
			close_frame(in_footer ? ST_DROP_FOOT : ST_DROP);
			return;
		end
		if (in_footer) begin
			if (!mk) begin
				close_frame(ST_DATA_FOOT);
				return;
			end
			if (b == END_BYTE) begin
				close_frame(ST_GOOD);
				return;
			end
		end else begin
			in_footer = mk;
		end
		word_pos = word_pos + 7'd1;
	endtask

	function automatic bit sender_pauses();
		return !steady && ($urandom_range(0, 99) < 31);
	endfunction

	task automatic send_word(input logic fv, input logic mk, input logic [7:0] b);
		while (sender_pauses()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, b, fv};
		s_tuser  <= mk;
		predict_word(fv, mk, b);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input logic [15:0] num, input int plain, input int marked,
	                          input frame_end_t ending);
		logic [7:0] b;
		for (int i = 0; i < plain; i++) begin
			if (i == 1)
				b = num[7:0];
			else if (i == 2)
				b = num[15:8];
			else
				b = 8'($urandom_range(0, 255));
			send_word(1'b1, 1'b0, b);
		end
		for (int j = 0; j < marked; j++)
			send_word(1'b1, 1'b1, 8'(j == 0 ? $urandom_range(0, 255) : $urandom_range(0, 254)));
		case (ending)
			END_GOOD: send_word(1'b1, 1'b1, END_BYTE);
			END_DROP: send_word(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			END_DATA: send_word(1'b1, 1'b0, 8'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	task automatic test_good_frames();
		send_word(1'b0, 1'b0, 8'h00);
		send_word(1'b0, 1'b1, 8'hFF);
		send_word(1'b1, 1'b0, 8'hAA);
		send_word(1'b1, 1'b0, 8'h01);
		send_word(1'b1, 1'b0, 8'h00);
		send_word(1'b1, 1'b1, END_BYTE);
		send_word(1'b1, 1'b1, END_BYTE);
		send_frame(16'hFFFF, 3, 1, END_GOOD);
		send_frame(16'h0000, 3, 1, END_GOOD);
		send_frame(16'h0000, 3, 0, END_GOOD);
	endtask

	task automatic test_error_frames();
		send_word(1'b1, 1'b0, 8'h33);
		send_word(1'b0, 1'b1, 8'h5A);
		send_frame(16'h1234, 3, 2, END_DATA);
		send_frame(16'h8001, 3, 1, END_DROP);
		send_frame(16'h7F00, 2, 0, END_DROP);
		send_frame(16'h0000, 0, 2, END_GOOD);
	endtask

	task automatic test_overflow();
		send_frame(16'hC0DE, FRAME_LIMIT + 1, 0, END_OPEN);
		send_word(1'b0, 1'b0, 8'h00);
		send_frame(16'h0102, 10, FRAME_LIMIT - 10, END_OPEN);
		send_word(1'b0, 1'b1, 8'h80);
		send_frame(16'h0203, 5, FRAME_LIMIT - 5, END_OPEN);
		send_frame(16'h0304, 3, 1, END_GOOD);
	endtask

	task automatic test_random();
		int start;
		int r;
		int plain;
		int marked;
		frame_end_t ending;
		start = words_taken;
		planned_seq = prev_seq;
		while (words_taken - start < RANDOM_WORDS) begin
			steady = (words_taken - start >= 500) && (words_taken - start < 800);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				          8'($urandom_range(0, 255)));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					planned_seq = planned_seq + 16'd1;
				else if (r < 80)
					planned_seq = 16'($urandom_range(0, 65535));
				else if (r < 94)
					planned_seq = 16'hFFFF;
				else if (r >= 97)
					planned_seq = 16'h0000;
				plain  = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70)
				                                     : $urandom_range(0, 6);
				marked = $urandom_range(0, 4);
				r = $urandom_range(0, 99);
				ending = (r < 70) ? END_GOOD : (r < 80) ? END_DROP :
				         (r < 90) ? END_DATA : END_OPEN;
				send_frame(planned_seq, plain, marked, ending);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		frame_open = 1'b0;
		word_pos   = '0;
		in_footer  = 1'b0;
		low_b      = '0;
		high_b     = '0;
		prev_seq   = '0;
		err_cnt    = '0;
		miss_cnt   = '0;
		good_cnt   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_good_frames();
		test_error_frames();
		test_overflow();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/mfrsc_pkg.sv
design/marked_frame_receiver_seq_check.sv
test/tb_marked_frame_receiver_seq_check.sv
